### design/mspd_pkg.sv
package mspd_pkg;

    // Field and state widths
    localparam int SPEED_W   = 13;
    localparam int TARGET_W  = 8;
    localparam int GAIN_W    = 16;
    localparam int DRIVE_W   = 8;
    localparam int ERR_W     = 10;             // target - rounded speed: -256..510
    localparam int DIFF_W    = ERR_W + 1;      // error change: -766..766
    localparam int SUM_WIDTH = 24;             // integral accumulator
    localparam int FRAC_W    = 4;              // Q8.4 speed fraction
    localparam int Q_FRAC    = 8;              // Q.8 drive units

    localparam int PROD_P_W  = ERR_W + GAIN_W;
    localparam int PROD_I_W  = SUM_WIDTH + GAIN_W;
    localparam int PROD_D_W  = DIFF_W + GAIN_W;
    localparam int TOTAL_W   = PROD_D_W + 1;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int TDATA_IN_W = 16;            // speed padded to whole bytes

    // Constants in Q.8
    localparam int FF_SCALE   = 640;           // 2.5 x target
    localparam int HALF_LSB   = 128;           // one half drive step
    localparam int DRIVE_MAX  = 255;
    localparam int SPEED_HALF = 8;             // one half in Q8.4

    // Register map
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SETPOINT     = 3'd0,
        CFG_GAIN_P       = 3'd1,
        CFG_GAIN_I       = 3'd2,
        CFG_GAIN_D       = 3'd3,
        CFG_INTEGRAL_MIN = 3'd4,
        CFG_INTEGRAL_MAX = 3'd5,
        CFG_MIN_DRIVE    = 3'd6
    } cfg_index_t;

    // Registered PID products handed to the output stage
    typedef struct packed {
        logic signed [PROD_P_W-1:0] up;
        logic signed [PROD_I_W-1:0] ui;
        logic signed [PROD_D_W-1:0] ud;
    } mspd_terms_t;

    // Static settings the output stage needs
    typedef struct packed {
        logic        [TARGET_W-1:0] setpoint;
        logic signed [GAIN_W-1:0]   integral_min;
        logic signed [GAIN_W-1:0]   integral_max;
        logic        [DRIVE_W-1:0]  min_drive;
    } mspd_limits_t;

endpackage

### design/mspd_drive_limit.sv
module mspd_drive_limit (
    input  mspd_pkg::mspd_terms_t       terms,
    input  mspd_pkg::mspd_limits_t      limits,
    output logic [mspd_pkg::DRIVE_W-1:0] drive
);
    import mspd_pkg::*;

    logic signed [PROD_I_W-1:0] i_min_ext;
    logic signed [PROD_I_W-1:0] i_max_ext;
    logic signed [PROD_I_W-1:0] ui_lo;
    logic signed [PROD_I_W-1:0] ui_cl;
    logic signed [GAIN_W-1:0]   ui_q;
    logic        [TOTAL_W-1:0]  ff_u;
    logic signed [TOTAL_W-1:0]  total;
    logic signed [TOTAL_W-1:0]  whole;

    assign i_min_ext = PROD_I_W'(limits.integral_min);
    assign i_max_ext = PROD_I_W'(limits.integral_max);

    // Raise to min first, then cap at max (max wins when clamps cross)
    always_comb begin
        ui_lo = (terms.ui < i_min_ext) ? i_min_ext : terms.ui;
        ui_cl = (ui_lo > i_max_ext) ? i_max_ext : ui_lo;
        ui_q  = ui_cl[GAIN_W-1:0];
    end

    assign ff_u  = TOTAL_W'(limits.setpoint) * TOTAL_W'(FF_SCALE);
    assign total = TOTAL_W'(terms.up) + TOTAL_W'(ui_q) + TOTAL_W'(terms.ud)
                 + $signed(ff_u) + TOTAL_W'(HALF_LSB);
    assign whole = total >>> Q_FRAC;

    always_comb begin
        if (total < 0) begin
            drive = '0;
        end else if (whole > TOTAL_W'(DRIVE_MAX)) begin
            drive = DRIVE_W'(DRIVE_MAX);
        end else begin
            drive = whole[DRIVE_W-1:0];
        end
        if (drive < limits.min_drive) begin
            drive = '0;
        end
    end

endmodule

### design/motor_speed_pid_drive_unit.sv
// PID speed controller with a clamped integral term and a 2.5 x target
// feedforward. Each request on the s_ side carries one measured speed in
// signed Q8.4 (s_tdata[12:0]); each request on the m_ side returns the 8-bit
// motor drive for it, one result per speed, in order. The block takes one
// request every cycle unless a full pipe is held by m_tready low, and each
// request passes through input register, error/integral stage, multiply
// stage and output register. The integral sum and the previous error update in
// the error/integral stage, a one-register loop, so back-to-back requests see
// each other's state exactly. Each stage moves on when the next one is
// free, so bubbles are squeezed out and s_tready drops only when all four
// stages hold data and m_tready is low. Settings are written through the
// cfg_ port (index = register number, write lands on the clock edge with
// cfg_wr_en high, unknown indexes ignored) and must only change while no
// request is in flight.
module motor_speed_pid_drive_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    // request in
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [mspd_pkg::TDATA_IN_W-1:0]    s_tdata,   // [12:0] measured_speed
    // result out
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [mspd_pkg::DRIVE_W-1:0]       m_tdata,   // [7:0] motor_drive
    // settings
    input  logic                               cfg_wr_en,
    input  logic [mspd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mspd_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import mspd_pkg::*;

    // ---------------- settings ----------------
    logic        [TARGET_W-1:0] setpoint_reg;
    logic signed [GAIN_W-1:0]   gain_p_reg;
    logic signed [GAIN_W-1:0]   gain_i_reg;
    logic signed [GAIN_W-1:0]   gain_d_reg;
    logic signed [GAIN_W-1:0]   integral_min_reg;
    logic signed [GAIN_W-1:0]   integral_max_reg;
    logic        [DRIVE_W-1:0]  min_drive_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            setpoint_reg     <= TARGET_W'(20);
            gain_p_reg       <= GAIN_W'(256);
            gain_i_reg       <= '0;
            gain_d_reg       <= '0;
            integral_min_reg <= {1'b1, {(GAIN_W-1){1'b0}}};
            integral_max_reg <= {1'b0, {(GAIN_W-1){1'b1}}};
            min_drive_reg    <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_SETPOINT:     setpoint_reg     <= cfg_wdata[TARGET_W-1:0];
                CFG_GAIN_P:       gain_p_reg       <= cfg_wdata[GAIN_W-1:0];
                CFG_GAIN_I:       gain_i_reg       <= cfg_wdata[GAIN_W-1:0];
                CFG_GAIN_D:       gain_d_reg       <= cfg_wdata[GAIN_W-1:0];
                CFG_INTEGRAL_MIN: integral_min_reg <= cfg_wdata[GAIN_W-1:0];
                CFG_INTEGRAL_MAX: integral_max_reg <= cfg_wdata[GAIN_W-1:0];
                CFG_MIN_DRIVE:    min_drive_reg    <= cfg_wdata[DRIVE_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- flow control ----------------
    logic st1_valid_reg, st2_valid_reg, st3_valid_reg, m_tvalid_reg;
    logic out_en, st3_en, st2_en, st1_en;

    assign out_en   = !m_tvalid_reg || m_tready;
    assign st3_en   = !st3_valid_reg || out_en;
    assign st2_en   = !st2_valid_reg || st3_en;
    assign st1_en   = !st1_valid_reg || st2_en;
    assign s_tready = st1_en;
    assign m_tvalid = m_tvalid_reg;

    logic st1_move;
    assign st1_move = st1_valid_reg && st2_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
            st2_valid_reg <= 1'b0;
            st3_valid_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (st1_en) st1_valid_reg <= s_tvalid;
            if (st2_en) st2_valid_reg <= st1_valid_reg;
            if (st3_en) st3_valid_reg <= st2_valid_reg;
            if (out_en) m_tvalid_reg  <= st3_valid_reg;
        end
    end

    // ---------------- stage 1: input register ----------------
    logic signed [SPEED_W-1:0] speed_reg;

    always_ff @(posedge aclk) begin
        if (st1_en && s_tvalid) begin
            speed_reg <= s_tdata[SPEED_W-1:0];
        end
    end

    // ---------------- error, derivative, integral ----------------
    logic signed [SPEED_W:0]    shifted;
    logic signed [SPEED_W:0]    shifted_adj;
    logic signed [SPEED_W:0]    rounded_w;
    logic signed [ERR_W-1:0]    rounded;
    logic signed [ERR_W:0]      err_w;
    logic signed [ERR_W-1:0]    err;
    logic signed [DIFF_W-1:0]   diff;
    logic signed [SUM_WIDTH:0]  sum_wide;
    logic signed [SUM_WIDTH-1:0] sum_next;

    logic signed [SUM_WIDTH-1:0] error_sum_reg;
    logic signed [ERR_W-1:0]     previous_error_reg;

    localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
    localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

    // round half up then truncate toward zero
    assign shifted     = (SPEED_W+1)'(speed_reg) + (SPEED_W+1)'(SPEED_HALF);
    assign shifted_adj = shifted[SPEED_W]
                       ? shifted + (SPEED_W+1)'((1 << FRAC_W) - 1)
                       : shifted;
    assign rounded_w   = shifted_adj >>> FRAC_W;
    assign rounded     = rounded_w[ERR_W-1:0];

    assign err_w = $signed({{(ERR_W+1-TARGET_W){1'b0}}, setpoint_reg})
                 - (ERR_W+1)'(rounded);
    assign err   = err_w[ERR_W-1:0];
    assign diff  = DIFF_W'(err) - DIFF_W'(previous_error_reg);

    // saturating accumulate
    assign sum_wide = (SUM_WIDTH+1)'(error_sum_reg) + (SUM_WIDTH+1)'(err);
    always_comb begin
        if (sum_wide[SUM_WIDTH] != sum_wide[SUM_WIDTH-1]) begin
            sum_next = sum_wide[SUM_WIDTH] ? SUM_MIN : SUM_MAX;
        end else begin
            sum_next = sum_wide[SUM_WIDTH-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            error_sum_reg      <= '0;
            previous_error_reg <= '0;
        end else if (st1_move) begin
            error_sum_reg      <= sum_next;
            previous_error_reg <= err;
        end
    end

    // ---------------- stage 2 registers ----------------
    logic signed [ERR_W-1:0]     st2_err_reg;
    logic signed [DIFF_W-1:0]    st2_diff_reg;
    logic signed [SUM_WIDTH-1:0] st2_sum_reg;

    always_ff @(posedge aclk) begin
        if (st1_move) begin
            st2_err_reg  <= err;
            st2_diff_reg <= diff;
            st2_sum_reg  <= sum_next;
        end
    end

    // ---------------- multiplies -> stage 3 ----------------
    mspd_terms_t terms_next, st3_terms_reg;

    always_comb begin
        terms_next.up = PROD_P_W'(st2_err_reg)  * PROD_P_W'(gain_p_reg);
        terms_next.ui = PROD_I_W'(st2_sum_reg)  * PROD_I_W'(gain_i_reg);
        terms_next.ud = PROD_D_W'(st2_diff_reg) * PROD_D_W'(gain_d_reg);
    end

    always_ff @(posedge aclk) begin
        if (st3_en && st2_valid_reg) begin
            st3_terms_reg <= terms_next;
        end
    end

    // ---------------- sum, clamp, output register ----------------
    mspd_limits_t limits;
    logic [DRIVE_W-1:0] drive_next;
    logic [DRIVE_W-1:0] m_tdata_reg;

    assign limits.setpoint     = setpoint_reg;
    assign limits.integral_min = integral_min_reg;
    assign limits.integral_max = integral_max_reg;
    assign limits.min_drive    = min_drive_reg;

    mspd_drive_limit u_drive_limit (
        .terms  (st3_terms_reg),
        .limits (limits),
        .drive  (drive_next)
    );

    always_ff @(posedge aclk) begin
        if (out_en && st3_valid_reg) begin
            m_tdata_reg <= drive_next;
        end
    end

    assign m_tdata = m_tdata_reg;

    // ---------------- checks ----------------
    // input side stalls only when the whole pipe is full and blocked
    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (st1_valid_reg && st2_valid_reg && st3_valid_reg
                       && m_tvalid && !m_tready))
        else $error("s_tready low with room in the pipe");

    // controller state moves only with a request leaving stage 1
    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !st1_move |=> ($stable(error_sum_reg) && $stable(previous_error_reg)))
        else $error("PID state changed without a request");

    a_prev_err: assert property (@(posedge aclk) disable iff (!aresetn)
        st1_move |=> (previous_error_reg == $past(err)))
        else $error("previous error not the last request's error");

    a_no_loss: assert property (@(posedge aclk) disable iff (!aresetn)
        st1_move |=> st2_valid_reg)
        else $error("request dropped between stage 1 and stage 2");

endmodule
